>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SRP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define SRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hw/rtl/srp_pkg.sv
// Types and constants for the secret record parser.
// No dependencies.
`default_nettype none
package srp_pkg;

  localparam int LEN_W = 10;
  typedef logic [LEN_W-1:0] len_t;

  localparam logic [7:0] LEAD_BYTE  = 8'hFF;
  localparam logic [7:0] SLASH_BYTE = 8'h2F;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;
  localparam logic [7:0] HASH_BYTE  = 8'h23;
  localparam logic [7:0] CTRL_MAX   = 8'h1F;
  localparam logic [7:0] DEL_BYTE   = 8'h7F;
  localparam logic [7:0] BAD_LEAD_MAX = 8'hC1;
  localparam logic [7:0] TWO_MAX    = 8'hDF;
  localparam logic [7:0] THREE_MAX  = 8'hEF;
  localparam logic [7:0] FOUR_MAX   = 8'hF4;
  localparam logic [7:0] E0_BYTE    = 8'hE0;
  localparam logic [7:0] ED_BYTE    = 8'hED;
  localparam logic [7:0] F0_BYTE    = 8'hF0;
  localparam logic [7:0] F4_BYTE    = 8'hF4;
  localparam logic [7:0] CONT_A0    = 8'hA0;
  localparam logic [7:0] CONT_8F    = 8'h8F;
  localparam logic [7:0] CONT_90    = 8'h90;

  // lead classes
  localparam logic [2:0] LC_PLAIN = 3'd0;
  localparam logic [2:0] LC_TWO   = 3'd1;
  localparam logic [2:0] LC_E0    = 3'd2;
  localparam logic [2:0] LC_ED    = 3'd3;
  localparam logic [2:0] LC_THREE = 3'd4;
  localparam logic [2:0] LC_F0    = 3'd5;
  localparam logic [2:0] LC_F4    = 3'd6;
  localparam logic [2:0] LC_FOUR  = 3'd7;

  // special kinds
  localparam logic [1:0] SK_NONE  = 2'd0;
  localparam logic [1:0] SK_QUERY = 2'd1;
  localparam logic [1:0] SK_HASH  = 2'd2;

  typedef struct packed {
    logic       err;
    logic       slash_seen;
    logic [1:0] special_kind;
    logic       hq_seen;
  } srp_flags_t;

endpackage
`default_nettype wire

>>> hw/rtl/srp_scan.sv
// Per-word scanner: lead/key skip, UTF-8 checks, separator tracking.
// Depends on srp_pkg. Holds a record summary register for srp_lens.
`default_nettype none
module srp_scan #(
  parameter int KEY_BYTES  = 16,
  parameter int MAX_DOMAIN = 512,
  localparam int OFF_W = $clog2(MAX_DOMAIN + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  output logic                    snap_valid,
  input  logic                    snap_ready,
  output srp_pkg::srp_flags_t     snap_flags,
  output logic [OFF_W-1:0]        snap_dlen,
  output logic [OFF_W-1:0]        snap_slash_off,
  output logic [OFF_W-1:0]        snap_special_off,
  output logic [OFF_W-1:0]        snap_hash_off
);
  import srp_pkg::*;

  localparam int REC_LIMIT = 1 + KEY_BYTES + MAX_DOMAIN;
  localparam int CNT_W     = $clog2(REC_LIMIT + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       cont_r, cont_nxt;
  logic [2:0]       lc_r, lc_nxt;
  logic             err_r, err_nxt;
  logic             sl_seen_r, sl_seen_nxt;
  logic [OFF_W-1:0] sl_off_r, sl_off_nxt;
  logic [1:0]       sk_r, sk_nxt;
  logic [OFF_W-1:0] sp_off_r, sp_off_nxt;
  logic             hq_r, hq_nxt;
  logic [OFF_W-1:0] hash_off_r, hash_off_nxt;

  logic             snap_vld_r;
  srp_flags_t       snap_flags_r, fin_flags;
  logic [OFF_W-1:0] snap_dlen_r, snap_sl_r, snap_sp_r, snap_hash_r, fin_dlen;

  logic             accept, in_domain;
  logic [OFF_W-1:0] off;
  logic [CNT_W-1:0] dl_wide;

  assign in_ready = !snap_vld_r || snap_ready;
  assign accept   = in_valid && in_ready;
  assign off      = OFF_W'(cnt_r - CNT_W'(KEY_BYTES + 1));

  always_comb begin
    cnt_nxt      = cnt_r;
    cont_nxt     = cont_r;
    lc_nxt       = lc_r;
    err_nxt      = err_r;
    sl_seen_nxt  = sl_seen_r;
    sl_off_nxt   = sl_off_r;
    sk_nxt       = sk_r;
    sp_off_nxt   = sp_off_r;
    hq_nxt       = hq_r;
    hash_off_nxt = hash_off_r;
    in_domain    = 1'b0;

    if (cnt_r >= CNT_W'(REC_LIMIT)) begin
      err_nxt = 1'b1;
    end else begin
      if (cnt_r == '0) begin
        if (data_byte != LEAD_BYTE) err_nxt = 1'b1;
      end else if (cnt_r > CNT_W'(KEY_BYTES)) begin
        in_domain = 1'b1;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (in_domain) begin
      priority if (cont_r != 2'd0) begin
        if (data_byte[7:6] != 2'b10) begin
          err_nxt = 1'b1;
        end else begin
          if (lc_r == LC_E0 && data_byte < CONT_A0) err_nxt = 1'b1;
          if (lc_r == LC_ED && data_byte >= CONT_A0) err_nxt = 1'b1;
          if (lc_r == LC_F0 && data_byte < CONT_90) err_nxt = 1'b1;
          if (lc_r == LC_F4 && data_byte > CONT_8F) err_nxt = 1'b1;
        end
        lc_nxt   = LC_PLAIN;
        cont_nxt = cont_r - 2'd1;
      end else if (data_byte <= CTRL_MAX || data_byte == DEL_BYTE) begin
        err_nxt = 1'b1;
      end else if (data_byte <= DEL_BYTE) begin
        // plain ASCII
      end else if (data_byte <= BAD_LEAD_MAX) begin
        err_nxt = 1'b1;
      end else if (data_byte <= TWO_MAX) begin
        cont_nxt = 2'd1;
        lc_nxt   = LC_TWO;
      end else if (data_byte <= THREE_MAX) begin
        cont_nxt = 2'd2;
        lc_nxt   = (data_byte == E0_BYTE) ? LC_E0 :
                   (data_byte == ED_BYTE) ? LC_ED : LC_THREE;
      end else if (data_byte <= FOUR_MAX) begin
        cont_nxt = 2'd3;
        lc_nxt   = (data_byte == F0_BYTE) ? LC_F0 :
                   (data_byte == F4_BYTE) ? LC_F4 : LC_FOUR;
      end else begin
        err_nxt = 1'b1;
      end

      if (off == '0 && data_byte == SLASH_BYTE) err_nxt = 1'b1;
      if (data_byte == SLASH_BYTE && !sl_seen_r) begin
        sl_seen_nxt = 1'b1;
        sl_off_nxt  = off;
      end
      if ((data_byte == QMARK_BYTE || data_byte == HASH_BYTE) && sk_r == SK_NONE) begin
        sk_nxt     = (data_byte == QMARK_BYTE) ? SK_QUERY : SK_HASH;
        sp_off_nxt = off;
      end else if (data_byte == HASH_BYTE && sk_r == SK_QUERY && !hq_r) begin
        hq_nxt       = 1'b1;
        hash_off_nxt = off;
      end
    end
  end

  // end-of-record checks
  assign dl_wide  = cnt_nxt - CNT_W'(KEY_BYTES + 1);
  assign fin_dlen = dl_wide[OFF_W-1:0];

  always_comb begin
    fin_flags.err          = err_nxt || (cnt_nxt < CNT_W'(KEY_BYTES + 2)) ||
                             (cont_nxt != 2'd0);
    fin_flags.slash_seen   = sl_seen_nxt;
    fin_flags.special_kind = sk_nxt;
    fin_flags.hq_seen      = hq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cont_r     <= 2'd0;
      lc_r       <= LC_PLAIN;
      err_r      <= 1'b0;
      sl_seen_r  <= 1'b0;
      sl_off_r   <= '0;
      sk_r       <= SK_NONE;
      sp_off_r   <= '0;
      hq_r       <= 1'b0;
      hash_off_r <= '0;
      snap_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          cnt_r      <= '0;
          cont_r     <= 2'd0;
          lc_r       <= LC_PLAIN;
          err_r      <= 1'b0;
          sl_seen_r  <= 1'b0;
          sl_off_r   <= '0;
          sk_r       <= SK_NONE;
          sp_off_r   <= '0;
          hq_r       <= 1'b0;
          hash_off_r <= '0;
        end else begin
          cnt_r      <= cnt_nxt;
          cont_r     <= cont_nxt;
          lc_r       <= lc_nxt;
          err_r      <= err_nxt;
          sl_seen_r  <= sl_seen_nxt;
          sl_off_r   <= sl_off_nxt;
          sk_r       <= sk_nxt;
          sp_off_r   <= sp_off_nxt;
          hq_r       <= hq_nxt;
          hash_off_r <= hash_off_nxt;
        end
      end
      if (accept && last_byte) begin
        snap_vld_r <= 1'b1;
      end else if (snap_ready) begin
        snap_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap_flags_r <= fin_flags;
      snap_dlen_r  <= fin_dlen;
      snap_sl_r    <= sl_off_nxt;
      snap_sp_r    <= sp_off_nxt;
      snap_hash_r  <= hash_off_nxt;
    end
  end

  assign snap_valid       = snap_vld_r;
  assign snap_flags       = snap_flags_r;
  assign snap_dlen        = snap_dlen_r;
  assign snap_slash_off   = snap_sl_r;
  assign snap_special_off = snap_sp_r;
  assign snap_hash_off    = snap_hash_r;

endmodule
`default_nettype wire

>>> hw/rtl/srp_lens.sv
// Length split of a finished record into host, path, query, fragment.
// Depends on srp_pkg. Owns the result register.
`default_nettype none
module srp_lens #(
  parameter int MAX_DOMAIN = 512,
  localparam int OFF_W = $clog2(MAX_DOMAIN + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                snap_valid,
  output logic                snap_ready,
  input  srp_pkg::srp_flags_t snap_flags,
  input  logic [OFF_W-1:0]    snap_dlen,
  input  logic [OFF_W-1:0]    snap_slash_off,
  input  logic [OFF_W-1:0]    snap_special_off,
  input  logic [OFF_W-1:0]    snap_hash_off,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                status,
  output srp_pkg::len_t       host_cnt,
  output srp_pkg::len_t       path_cnt,
  output srp_pkg::len_t       query_cnt,
  output srp_pkg::len_t       frag_cnt
);
  import srp_pkg::*;

  localparam int EXT_W = (OFF_W > LEN_W) ? OFF_W : LEN_W;

  function automatic len_t fit(input logic [OFF_W-1:0] v);
    logic [EXT_W-1:0] w;
    w = EXT_W'(v);
    return w[LEN_W-1:0];
  endfunction

  logic             out_vld_r;
  logic             status_r;
  len_t             host_r, path_r, query_r, frag_r;
  logic             take, sp_in_host;
  logic [OFF_W-1:0] host, path, query, frag;

  assign snap_ready = !out_vld_r || out_ready;
  assign take       = snap_valid && snap_ready;

  always_comb begin
    host  = '0;
    path  = '0;
    query = '0;
    frag  = '0;
    sp_in_host = (snap_flags.special_kind != SK_NONE) &&
                 (!snap_flags.slash_seen || snap_special_off < snap_slash_off);
    if (!snap_flags.err) begin
      if (sp_in_host) begin
        host = snap_special_off;
      end else begin
        host = snap_flags.slash_seen ? snap_slash_off : snap_dlen;
        path = (snap_flags.special_kind != SK_NONE) ? snap_special_off - host
                                                    : snap_dlen - host;
      end
      unique case (snap_flags.special_kind)
        SK_HASH: begin
          frag = snap_dlen - snap_special_off - OFF_W'(1);
        end
        SK_QUERY: begin
          if (snap_flags.hq_seen) begin
            query = snap_hash_off - snap_special_off - OFF_W'(1);
            frag  = snap_dlen - snap_hash_off - OFF_W'(1);
          end else begin
            query = snap_dlen - snap_special_off - OFF_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status_r <= snap_flags.err;
      host_r   <= fit(host);
      path_r   <= fit(path);
      query_r  <= fit(query);
      frag_r   <= fit(frag);
    end
  end

  assign out_valid = out_vld_r;
  assign status    = status_r;
  assign host_cnt  = host_r;
  assign path_cnt  = path_r;
  assign query_cnt = query_r;
  assign frag_cnt  = frag_r;

endmodule
`default_nettype wire

>>> hw/rtl/secret_record_parser.sv
// Top level of the secret record parser: srp_scan feeding srp_lens.
// Depends on srp_pkg, srp_scan, srp_lens and assert_macros.svh.
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_ready  | in_data_byte[7:0], in_last_byte
//  out     | out_valid/out_ready| out_status, out_host/path/query/frag_cnt
//
// One word accepted per cycle while in_ready is high; the per-word checks
// update the scan state in the cycle of acceptance. A result for a record
// passes through the record summary register, then the result register.
// Reset (rst_n low, synchronous) clears the scan state and both valid flags.
// in_ready falls only while both summary and result registers are full and
// out_ready is low.
`default_nettype none
`include "assert_macros.svh"
module secret_record_parser #(
  parameter int MAX_DOMAIN = 512,
  parameter int KEY_BYTES  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_status,
  output srp_pkg::len_t       out_host_cnt,
  output srp_pkg::len_t       out_path_cnt,
  output srp_pkg::len_t       out_query_cnt,
  output srp_pkg::len_t       out_frag_cnt
);
  import srp_pkg::*;

  localparam int OFF_W = $clog2(MAX_DOMAIN + 1);

  logic             snap_vld, snap_rdy;
  srp_flags_t       snap_flags;
  logic [OFF_W-1:0] snap_dlen, snap_sl, snap_sp, snap_hash;
  logic             lens_zero;

  srp_scan #(
    .KEY_BYTES  (KEY_BYTES),
    .MAX_DOMAIN (MAX_DOMAIN)
  ) u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (in_data_byte),
    .last_byte        (in_last_byte),
    .snap_valid       (snap_vld),
    .snap_ready       (snap_rdy),
    .snap_flags       (snap_flags),
    .snap_dlen        (snap_dlen),
    .snap_slash_off   (snap_sl),
    .snap_special_off (snap_sp),
    .snap_hash_off    (snap_hash)
  );

  srp_lens #(
    .MAX_DOMAIN (MAX_DOMAIN)
  ) u_lens (
    .clk              (clk),
    .rst_n            (rst_n),
    .snap_valid       (snap_vld),
    .snap_ready       (snap_rdy),
    .snap_flags       (snap_flags),
    .snap_dlen        (snap_dlen),
    .snap_slash_off   (snap_sl),
    .snap_special_off (snap_sp),
    .snap_hash_off    (snap_hash),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (out_status),
    .host_cnt         (out_host_cnt),
    .path_cnt         (out_path_cnt),
    .query_cnt        (out_query_cnt),
    .frag_cnt         (out_frag_cnt)
  );

  assign lens_zero = (out_host_cnt == '0) && (out_path_cnt == '0) &&
                     (out_query_cnt == '0) && (out_frag_cnt == '0);

  `SRP_ASSERT_IMPLY(a_bad_zero, clk, rst_n, out_valid && out_status, lens_zero)
  `SRP_ASSERT_NEXT(a_last_snap, clk, rst_n, in_valid && in_ready && in_last_byte, snap_vld)
  `SRP_ASSERT_IMPLY(a_stall_full, clk, rst_n, !in_ready, snap_vld && out_valid && !out_ready)

endmodule
`default_nettype wire

>>> tb/tb_secret_record_parser.sv
`timescale 1ns / 1ps
// Testbench for secret_record_parser: streams directed and random records,
// predicts each record summary as its words are accepted and checks each result.
// Depends on srp_pkg and the secret_record_parser RTL.
module tb_secret_record_parser;
  import srp_pkg::*;

  localparam int KEY_LEN = 16;
  localparam int DOM_MAX = 512;
  localparam int REC_CAP = 1 + KEY_LEN + DOM_MAX;

  typedef logic [7:0] octet_t;
  typedef struct packed {
    logic status;
    len_t host_cnt;
    len_t path_cnt;
    len_t query_cnt;
    len_t frag_cnt;
  } rec_summary_t;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  octet_t in_data_byte;
  logic   in_last_byte;
  logic   out_valid;
  logic   out_ready;
  logic   out_status;
  len_t   out_host_cnt;
  len_t   out_path_cnt;
  len_t   out_query_cnt;
  len_t   out_frag_cnt;

  secret_record_parser #(
    .MAX_DOMAIN(DOM_MAX),
    .KEY_BYTES(KEY_LEN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_host_cnt(out_host_cnt),
    .out_path_cnt(out_path_cnt),
    .out_query_cnt(out_query_cnt),
    .out_frag_cnt(out_frag_cnt)
  );

  // record tracker state
  int         rec_pos;
  int         cont_left;
  logic [2:0] lead_kind;
  bit         rec_bad;
  bit         slash_hit;
  int         slash_at;
  logic [1:0] spec_kind;
  int         spec_at;
  bit         hash_hit;
  int         hash_at;

  rec_summary_t due_summaries[$];
  octet_t       rec_buf[$];
  int           mismatches;
  int           words_sent;
  int           records_sent;
  int           hold_len;
  bit           hold_req;
  bit           burst_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void clear_record_state();
    rec_pos   = 0;
    cont_left = 0;
    lead_kind = LC_PLAIN;
    rec_bad   = 1'b0;
    slash_hit = 1'b0;
    slash_at  = 0;
    spec_kind = SK_NONE;
    spec_at   = 0;
    hash_hit  = 1'b0;
    hash_at   = 0;
  endfunction

  function automatic void scan_domain_octet(input octet_t b, input int off);
    if (cont_left != 0) begin
      if (b[7:6] != 2'b10) begin
        rec_bad = 1'b1;
      end else begin
        if (lead_kind == LC_E0 && b < CONT_A0) rec_bad = 1'b1;
        if (lead_kind == LC_ED && b >= CONT_A0) rec_bad = 1'b1;
        if (lead_kind == LC_F0 && b < CONT_90) rec_bad = 1'b1;
        if (lead_kind == LC_F4 && b > CONT_8F) rec_bad = 1'b1;
      end
      lead_kind = LC_PLAIN;
      cont_left--;
    end else if (b <= CTRL_MAX || b == DEL_BYTE) begin
      rec_bad = 1'b1;
    end else if (b < DEL_BYTE) begin
      // plain ASCII
    end else if (b <= BAD_LEAD_MAX) begin
      rec_bad = 1'b1;
    end else if (b <= TWO_MAX) begin
      cont_left = 1;
      lead_kind = LC_TWO;
    end else if (b <= THREE_MAX) begin
      cont_left = 2;
      lead_kind = (b == E0_BYTE) ? LC_E0 : (b == ED_BYTE) ? LC_ED : LC_THREE;
    end else if (b <= FOUR_MAX) begin
      cont_left = 3;
      lead_kind = (b == F0_BYTE) ? LC_F0 : (b == F4_BYTE) ? LC_F4 : LC_FOUR;
    end else begin
      rec_bad = 1'b1;
    end

    if (off == 0 && b == SLASH_BYTE) rec_bad = 1'b1;
    if (b == SLASH_BYTE && !slash_hit) begin
      slash_hit = 1'b1;
      slash_at  = off;
    end
    if ((b == QMARK_BYTE || b == HASH_BYTE) && spec_kind == SK_NONE) begin
      spec_kind = (b == QMARK_BYTE) ? SK_QUERY : SK_HASH;
      spec_at   = off;
    end else if (b == HASH_BYTE && spec_kind == SK_QUERY && !hash_hit) begin
      hash_hit = 1'b1;
      hash_at  = off;
    end
  endfunction

  function automatic void track_record_word(input octet_t b, input logic is_last);
    rec_summary_t s;
    int dlen;
    int host  = 0;
    int path  = 0;
    int query = 0;
    int frag  = 0;
    if (rec_pos >= REC_CAP) begin
      rec_bad = 1'b1;
    end else begin
      if (rec_pos == 0) begin
        if (b != LEAD_BYTE) rec_bad = 1'b1;
      end else if (rec_pos > KEY_LEN) begin
        scan_domain_octet(b, rec_pos - 1 - KEY_LEN);
      end
      rec_pos++;
    end
    if (!is_last) return;

    if (rec_pos < KEY_LEN + 2) rec_bad = 1'b1;
    if (cont_left != 0) rec_bad = 1'b1;
    if (!rec_bad) begin
      dlen = rec_pos - 1 - KEY_LEN;
      if (spec_kind != SK_NONE && (!slash_hit || spec_at < slash_at)) begin
        host = spec_at;
      end else begin
        host = slash_hit ? slash_at : dlen;
        path = (spec_kind != SK_NONE) ? spec_at - host : dlen - host;
      end
      if (spec_kind == SK_HASH) begin
        frag = dlen - spec_at - 1;
      end else if (spec_kind == SK_QUERY) begin
        if (hash_hit) begin
          query = hash_at - spec_at - 1;
          frag  = dlen - hash_at - 1;
        end else begin
          query = dlen - spec_at - 1;
        end
      end
    end
    s.status    = rec_bad;
    s.host_cnt  = len_t'(host);
    s.path_cnt  = len_t'(path);
    s.query_cnt = len_t'(query);
    s.frag_cnt  = len_t'(frag);
    due_summaries.push_back(s);
    clear_record_state();
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) track_record_word(in_data_byte, in_last_byte);
  end

  always @(posedge clk) begin
    rec_summary_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_summaries.size() == 0) begin
        flag_mismatch("result with no record pending", 1, 0);
      end else begin
        want = due_summaries.pop_front();
        if (out_status !== want.status)
          flag_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_host_cnt !== want.host_cnt)
          flag_mismatch("host count", 32'(out_host_cnt), 32'(want.host_cnt));
        if (out_path_cnt !== want.path_cnt)
          flag_mismatch("path count", 32'(out_path_cnt), 32'(want.path_cnt));
        if (out_query_cnt !== want.query_cnt)
          flag_mismatch("query count", 32'(out_query_cnt), 32'(want.query_cnt));
        if (out_frag_cnt !== want.frag_cnt)
          flag_mismatch("fragment count", 32'(out_frag_cnt), 32'(want.frag_cnt));
      end
    end
  end

  function automatic int draw_gap();
    if (burst_mode || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        stall    = hold_len;
        hold_req = 1'b0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  task automatic send_word(input octet_t b, input logic is_last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= is_last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_record();
    foreach (rec_buf[i]) send_word(rec_buf[i], i == rec_buf.size() - 1);
    records_sent++;
  endtask

  // key_fill < 0 gives random key words
  task automatic begin_record(input octet_t lead, input int key_fill, input int key_n);
    rec_buf.delete();
    rec_buf.push_back(lead);
    repeat (key_n)
      rec_buf.push_back((key_fill < 0) ? octet_t'($urandom_range(0, 255)) : octet_t'(key_fill));
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rec_buf.push_back(s[i]);
  endtask

  task automatic push_seq(input logic [31:0] seq, input int n);
    for (int i = 0; i < n; i++) rec_buf.push_back(seq[31-8*i -: 8]);
  endtask

  task automatic push_fill(input octet_t b, input int n);
    repeat (n) rec_buf.push_back(b);
  endtask

  function automatic octet_t any_cont();
    return octet_t'($urandom_range(8'h80, 8'hBF));
  endfunction

  task automatic push_random_token(input bit clean);
    int sel;
    int kind;
    octet_t lead;
    sel = clean ? $urandom_range(0, 79) : $urandom_range(0, 99);
    if (sel < 40) begin
      rec_buf.push_back(octet_t'($urandom_range(8'h20, 8'h7E)));
    end else if (sel < 48) begin
      rec_buf.push_back(SLASH_BYTE);
    end else if (sel < 53) begin
      rec_buf.push_back(QMARK_BYTE);
    end else if (sel < 58) begin
      rec_buf.push_back(HASH_BYTE);
    end else if (sel < 80) begin
      kind = $urandom_range(0, 6);
      case (kind)
        0: begin
          rec_buf.push_back(octet_t'($urandom_range(8'hC2, TWO_MAX)));
          rec_buf.push_back(any_cont());
        end
        1: begin
          rec_buf.push_back(E0_BYTE);
          rec_buf.push_back(octet_t'($urandom_range(CONT_A0, 8'hBF)));
          rec_buf.push_back(any_cont());
        end
        2: begin
          lead = octet_t'($urandom_range(8'hE1, THREE_MAX));
          if (lead == ED_BYTE) lead = 8'hEE;
          rec_buf.push_back(lead);
          rec_buf.push_back(any_cont());
          rec_buf.push_back(any_cont());
        end
        3: begin
          rec_buf.push_back(ED_BYTE);
          rec_buf.push_back(octet_t'($urandom_range(8'h80, 8'h9F)));
          rec_buf.push_back(any_cont());
        end
        4: begin
          rec_buf.push_back(F0_BYTE);
          rec_buf.push_back(octet_t'($urandom_range(CONT_90, 8'hBF)));
          rec_buf.push_back(any_cont());
          rec_buf.push_back(any_cont());
        end
        5: begin
          rec_buf.push_back(octet_t'($urandom_range(8'hF1, 8'hF3)));
          repeat (3) rec_buf.push_back(any_cont());
        end
        default: begin
          rec_buf.push_back(F4_BYTE);
          rec_buf.push_back(octet_t'($urandom_range(8'h80, CONT_8F)));
          rec_buf.push_back(any_cont());
          rec_buf.push_back(any_cont());
        end
      endcase
    end else if (sel < 90) begin
      rec_buf.push_back(octet_t'($urandom_range(0, 255)));
    end else if (sel < 95) begin
      rec_buf.push_back(octet_t'($urandom_range(8'hE0, FOUR_MAX)));
      rec_buf.push_back(octet_t'($urandom_range(0, 255)));
    end else begin
      rec_buf.push_back(($urandom_range(0, 4) == 0) ? DEL_BYTE
                                                    : octet_t'($urandom_range(0, CTRL_MAX)));
    end
  endtask

  task automatic test_framing();
    begin_record(LEAD_BYTE, -1, 0);
    send_record();
    begin_record(8'h00, -1, 0);
    send_record();
    begin_record(LEAD_BYTE, -1, KEY_LEN - 1);
    send_record();
    begin_record(LEAD_BYTE, -1, KEY_LEN);
    send_record();
    begin_record(8'hFE, -1, KEY_LEN);
    push_text("a");
    send_record();
    begin_record(LEAD_BYTE, 8'h00, KEY_LEN);
    push_text("a");
    send_record();
    begin_record(LEAD_BYTE, 8'hFF, KEY_LEN);
    push_text("b/");
    send_record();
  endtask

  task automatic test_host_path_split();
    string doms[12] = '{"example.org/dir/x", "h?q/x", "h/p#f?g", "h/p?q#f#g", "h/p?#",
                        "#", "?a/b", "a//b?", "/abc", "a/b/c", "x#y#z", "host"};
    foreach (doms[i]) begin
      begin_record(LEAD_BYTE, -1, KEY_LEN);
      push_text(doms[i]);
      send_record();
    end
  endtask

  task automatic test_utf8_rules();
    logic [31:0] bad_seq[16] = '{32'h1F00_0000, 32'h7F00_0000, 32'h0000_0000, 32'h8000_0000,
                                 32'hC080_0000, 32'hC1BF_0000, 32'hF580_8080, 32'hFF00_0000,
                                 32'hE09F_8000, 32'hEDA0_8000, 32'hF08F_BFBF, 32'hF490_8080,
                                 32'hE241_8200, 32'hC300_0000, 32'hF090_8000, 32'hC2C2_8000};
    int bad_n[16] = '{1, 1, 1, 1, 2, 2, 4, 1, 3, 3, 4, 4, 3, 1, 3, 3};
    bit at_end[16] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0};
    begin_record(LEAD_BYTE, -1, KEY_LEN);
    push_text("u");
    push_seq(32'hC280_0000, 2);
    push_seq(32'hDFBF_0000, 2);
    push_seq(32'hE0A0_8000, 3);
    push_seq(32'hE180_8000, 3);
    push_seq(32'hED9F_BF00, 3);
    push_seq(32'hEE80_8000, 3);
    push_seq(32'hEFBF_BF00, 3);
    push_seq(32'hF090_8080, 4);
    push_seq(32'hF180_8080, 4);
    push_seq(32'hF3BF_BFBF, 4);
    push_seq(32'hF48F_BFBF, 4);
    push_text("/~");
    send_record();
    foreach (bad_seq[i]) begin
      begin_record(LEAD_BYTE, -1, KEY_LEN);
      push_text("a");
      push_seq(bad_seq[i], bad_n[i]);
      if (!at_end[i]) push_text("z");
      send_record();
    end
  endtask

  task automatic test_length_limits();
    burst_mode = 1'b1;
    begin_record(LEAD_BYTE, -1, KEY_LEN);
    push_fill("x", DOM_MAX);
    send_record();
    begin_record(LEAD_BYTE, -1, KEY_LEN);
    push_fill("x", 300);
    push_text("?");
    push_fill("y", DOM_MAX - 301);
    send_record();
    begin_record(LEAD_BYTE, -1, KEY_LEN);
    push_fill("a", DOM_MAX - 1);
    push_text("/");
    send_record();
    begin_record(LEAD_BYTE, -1, KEY_LEN);
    push_fill("z", DOM_MAX + 3);
    send_record();
    burst_mode = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_len   = 400;
    hold_req   = 1'b1;
    burst_mode = 1'b1;
    repeat (8) begin
      begin_record(LEAD_BYTE, -1, KEY_LEN);
      push_text("a/b?c");
      send_record();
    end
    burst_mode = 1'b0;
  endtask

  task automatic test_random_records();
    int kind;
    int n;
    bit clean;
    words_sent   = 0;
    records_sent = 0;
    while (words_sent < 650 || records_sent < 40) begin
      burst_mode = ($urandom_range(0, 5) == 0);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        rec_buf.delete();
        repeat ($urandom_range(1, 30)) rec_buf.push_back(octet_t'($urandom_range(0, 255)));
      end else if (kind == 1) begin
        begin_record(LEAD_BYTE, -1, $urandom_range(0, KEY_LEN));
      end else begin
        begin_record(LEAD_BYTE, -1, KEY_LEN);
        clean = ($urandom_range(0, 3) != 0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
        repeat (n) push_random_token(clean);
      end
      send_record();
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    mismatches   = 0;
    words_sent   = 0;
    records_sent = 0;
    hold_len     = 0;
    hold_req     = 1'b0;
    burst_mode   = 1'b0;
    clear_record_state();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_framing();
    test_host_path_split();
    test_utf8_rules();
    test_length_limits();
    test_backpressure();
    test_random_records();

    in_valid <= 1'b0;
    while (due_summaries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
